// ----- design/rti_pkg.sv -----
// Shared types and codes for the row table with insert and delete.
package rti_pkg;

  localparam int DATA_W = 32;

  // action codes
  localparam logic [1:0] ACT_STAGE  = 2'd0;
  localparam logic [1:0] ACT_INSERT = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_READ   = 2'd3;

  // status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BAD_POS = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_BAD_COL = 3'd4;

  // row cell load select
  localparam logic [1:0] SEL_HOLD  = 2'd0;
  localparam logic [1:0] SEL_PREV  = 2'd1;
  localparam logic [1:0] SEL_NEXT  = 2'd2;
  localparam logic [1:0] SEL_STAGE = 2'd3;

  typedef struct packed {
    logic [1:0] sel;
    logic       rd_en;
  } cell_ctrl_t;

endpackage

// ----- design/row_table_insert_delete.sv -----
// Each result is registered when its item is accepted.
// Throughput: one item per cycle while not stalled; on insert or delete
// the row cells from the position up load the staged or a neighbor's row.
// Input is stalled only while a registered result waits on the output.
// Reset: row count zero, pending row all zero, columns_in_use 16; the
// row cells are not cleared and read only rows written by an insert.
module row_table_insert_delete import rti_pkg::*; #(
  parameter int MAX_ROWS = 16,
  parameter int MAX_COLS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         action,
  input  logic [4:0]         position,
  input  logic [3:0]         column,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         status,
  output logic [4:0]         row_count,
  output logic signed [31:0] read_value,
  input  logic               cfg_write,
  input  logic [4:0]         cfg_data
);

  localparam int CNT_W = $clog2(MAX_ROWS + 1);
  localparam int CW    = (CNT_W > 5) ? CNT_W : 5;
  localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CFG_W = ($clog2(MAX_COLS + 1) > 5) ? $clog2(MAX_COLS + 1) : 5;

  typedef logic [MAX_COLS-1:0][DATA_W-1:0] row_t;

  logic [4:0]        columns_in_use;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_next;
  row_t              staging;
  logic              accept;
  logic [CW-1:0]     pos_ext;
  logic [CW-1:0]     cnt_ext;
  logic [CFG_W-1:0]  cfg_ext;
  logic [CFG_W-1:0]  cols;
  logic [CFG_W-1:0]  col_ext;
  logic [COL_W-1:0]  col_idx;
  logic              ins_ok;
  logic              del_ok;
  logic              rd_ok;
  logic [2:0]        status_next;
  logic [DATA_W-1:0] rd_or;

  cell_ctrl_t                   ctrl [MAX_ROWS];
  row_t                         rows [MAX_ROWS];
  logic [MAX_ROWS-1:0][DATA_W-1:0] elems;
  logic [MAX_ROWS-1:0]          rd_en_vec;

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid && out_stall;

  assign pos_ext = CW'(position);
  assign cnt_ext = CW'(cnt);
  assign cfg_ext = CFG_W'(columns_in_use);
  assign col_ext = CFG_W'(column);
  assign col_idx = COL_W'(column);

  // clamp the used column count to 1..MAX_COLS
  always_comb begin
    if (cfg_ext == '0) begin
      cols = CFG_W'(1);
    end else if (cfg_ext > CFG_W'(MAX_COLS)) begin
      cols = CFG_W'(MAX_COLS);
    end else begin
      cols = cfg_ext;
    end
  end

  always_comb begin
    status_next = ST_OK;
    ins_ok      = 1'b0;
    del_ok      = 1'b0;
    rd_ok       = 1'b0;
    cnt_next    = cnt;
    unique case (action)
      ACT_STAGE: begin
        if (col_ext >= cols) status_next = ST_BAD_COL;
      end
      ACT_INSERT: begin
        if (pos_ext > cnt_ext) begin
          status_next = ST_BAD_POS;
        end else if (cnt >= CNT_W'(MAX_ROWS)) begin
          status_next = ST_FULL;
        end else begin
          ins_ok   = 1'b1;
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ACT_DELETE: begin
        if (cnt == '0) begin
          status_next = ST_EMPTY;
        end else if (pos_ext >= cnt_ext) begin
          status_next = ST_BAD_POS;
        end else begin
          del_ok   = 1'b1;
          cnt_next = cnt - CNT_W'(1);
        end
      end
      ACT_READ: begin
        if (pos_ext >= cnt_ext) begin
          status_next = ST_BAD_POS;
        end else if (col_ext >= cols) begin
          status_next = ST_BAD_COL;
        end else begin
          rd_ok = 1'b1;
        end
      end
    endcase
  end

  // per-cell load select and read enable
  always_comb begin
    for (int i = 0; i < MAX_ROWS; i++) begin
      ctrl[i].sel   = SEL_HOLD;
      ctrl[i].rd_en = (CW'(i) == pos_ext);
      rd_en_vec[i]  = ctrl[i].rd_en;
      if (accept && ins_ok) begin
        if (CW'(i) > pos_ext) begin
          ctrl[i].sel = SEL_PREV;
        end else if (CW'(i) == pos_ext) begin
          ctrl[i].sel = SEL_STAGE;
        end
      end else if (accept && del_ok) begin
        if (CW'(i) >= pos_ext) ctrl[i].sel = SEL_NEXT;
      end
    end
  end

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    rti_row_cell #(
      .MAX_COLS (MAX_COLS),
      .COL_W    (COL_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl[g]),
      .prev_row  ((g == 0) ? staging : rows[(g == 0) ? 0 : g - 1]),
      .next_row  ((g == MAX_ROWS - 1) ? rows[g] : rows[(g == MAX_ROWS - 1) ? g : g + 1]),
      .stage_row (staging),
      .rd_col    (col_idx),
      .row       (rows[g]),
      .elem      (elems[g])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < MAX_ROWS; i++) begin
      rd_or = rd_or | elems[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      columns_in_use <= 5'd16;
    end else if (cfg_write) begin
      columns_in_use <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt     <= '0;
      staging <= '0;
    end else if (accept) begin
      cnt <= cnt_next;
      if (action == ACT_STAGE && status_next == ST_OK) begin
        staging[col_idx] <= value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      row_count  <= 5'(cnt_next);
      read_value <= rd_ok ? rd_or : '0;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(MAX_ROWS))
    else $error("row count above table size");

  a_ins_grow: assert property (@(posedge clk) disable iff (rst)
    (accept && ins_ok) |=> cnt == $past(cnt) + CNT_W'(1))
    else $error("insert did not grow the count");

  a_del_shrink: assert property (@(posedge clk) disable iff (rst)
    (accept && del_ok) |=> cnt == $past(cnt) - CNT_W'(1))
    else $error("delete did not shrink the count");

  a_one_reader: assert property (@(posedge clk) disable iff (rst)
    $onehot0(rd_en_vec))
    else $error("more than one row cell selected for read");

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> read_value == '0)
    else $error("failed item returned a nonzero read value");

endmodule

// ----- design/rti_row_cell.sv -----
// One row of the table: holds a full row, loads the staged row or shifts to or from its neighbors.
module rti_row_cell import rti_pkg::*; #(
  parameter int MAX_COLS = 16,
  parameter int COL_W    = 4
) (
  input  logic                             clk,
  input  cell_ctrl_t                       ctrl,
  input  logic [MAX_COLS-1:0][DATA_W-1:0]  prev_row,
  input  logic [MAX_COLS-1:0][DATA_W-1:0]  next_row,
  input  logic [MAX_COLS-1:0][DATA_W-1:0]  stage_row,
  input  logic [COL_W-1:0]                 rd_col,
  output logic [MAX_COLS-1:0][DATA_W-1:0]  row,
  output logic [DATA_W-1:0]                elem
);

  always_ff @(posedge clk) begin
    unique case (ctrl.sel)
      SEL_HOLD:  row <= row;
      SEL_PREV:  row <= prev_row;
      SEL_NEXT:  row <= next_row;
      SEL_STAGE: row <= stage_row;
    endcase
  end

  // gated so the top can OR all cells together
  assign elem = ctrl.rd_en ? row[rd_col] : '0;

endmodule

// ----- tb/row_table_insert_delete_tb.sv -----
// Self-checking testbench for row_table_insert_delete: scoreboard class plus random driver.

typedef struct {
  logic [2:0]  status;
  logic [4:0]  row_count;
  logic [31:0] read_value;
} table_result_t;

class row_table_checker;
  localparam int ROWS = 16;
  localparam int COLS = 16;

  logic [31:0]   rows [ROWS][COLS];
  logic [31:0]   pending_row [COLS];
  int unsigned   count;
  logic [4:0]    col_limit;
  table_result_t expected_results [$];
  int            errors;
  int            items_seen;
  int            results_seen;
  int            status_hits [5];

  function void clear_state();
    for (int i = 0; i < COLS; i++) pending_row[i] = '0;
    for (int r = 0; r < ROWS; r++)
      for (int i = 0; i < COLS; i++) rows[r][i] = '0;
    count = 0;
    col_limit = 5'd16;
  endfunction

  function void set_columns(logic [4:0] v);
    col_limit = v;
  endfunction

  // zero acts as one, anything above the width acts as the full width
  function int unsigned active_cols();
    if (col_limit < 1) return 1;
    if (col_limit > COLS) return COLS;
    return 32'(col_limit);
  endfunction

  function int pending();
    return expected_results.size();
  endfunction

  function void apply_item(logic [1:0] act, logic [4:0] pos, logic [3:0] col,
                           logic [31:0] val);
    table_result_t res;
    int unsigned   cols;
    cols = active_cols();
    res.status = rti_pkg::ST_OK;
    res.read_value = '0;
    case (act)
      rti_pkg::ACT_STAGE: begin
        if (col >= cols) res.status = rti_pkg::ST_BAD_COL;
        else pending_row[col] = val;
      end
      rti_pkg::ACT_INSERT: begin
        if (pos > count) res.status = rti_pkg::ST_BAD_POS;
        else if (count >= ROWS) res.status = rti_pkg::ST_FULL;
        else begin
          for (int r = count; r > pos; r--)
            for (int i = 0; i < COLS; i++) rows[r][i] = rows[r-1][i];
          for (int i = 0; i < COLS; i++) rows[pos][i] = pending_row[i];
          count++;
        end
      end
      rti_pkg::ACT_DELETE: begin
        if (count == 0) res.status = rti_pkg::ST_EMPTY;
        else if (pos >= count) res.status = rti_pkg::ST_BAD_POS;
        else begin
          for (int r = pos; r < count - 1; r++)
            for (int i = 0; i < COLS; i++) rows[r][i] = rows[r+1][i];
          count--;
        end
      end
      default: begin
        if (pos >= count) res.status = rti_pkg::ST_BAD_POS;
        else if (col >= cols) res.status = rti_pkg::ST_BAD_COL;
        else res.read_value = rows[pos][col];
      end
    endcase
    res.row_count = count[4:0];
    status_hits[res.status]++;
    items_seen++;
    expected_results.push_back(res);
  endfunction

  function void match_result(logic [2:0] st, logic [4:0] rc, logic [31:0] rv);
    table_result_t exp_res;
    results_seen++;
    if (expected_results.size() == 0) begin
      $error("result with no item outstanding: status %0d row_count %0d read_value %0h",
             st, rc, rv);
      errors++;
      return;
    end
    exp_res = expected_results.pop_front();
    if (st !== exp_res.status) begin
      $error("status: expected %0d, got %0d", exp_res.status, st);
      errors++;
    end
    if (rc !== exp_res.row_count) begin
      $error("row_count: expected %0d, got %0d", exp_res.row_count, rc);
      errors++;
    end
    if (rv !== exp_res.read_value) begin
      $error("read_value: expected %0h, got %0h", exp_res.read_value, rv);
      errors++;
    end
  endfunction
endclass

module row_table_insert_delete_tb;
  import rti_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT  = 3000;
  localparam int PHASE_ITEMS = 112;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         action = ACT_STAGE;
  logic [4:0]         position = '0;
  logic [3:0]         column = '0;
  logic signed [31:0] value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [2:0]         status;
  logic [4:0]         row_count;
  logic signed [31:0] read_value;
  logic               cfg_write = 1'b0;
  logic [4:0]         cfg_data = '0;

  row_table_checker sb;
  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int idle_cycles = 0;
  int settings_used = 0;

  row_table_insert_delete dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .position(position), .column(column), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .row_count(row_count), .read_value(read_value),
    .cfg_write(cfg_write), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_item(logic [1:0] a, logic [4:0] p, logic [3:0] c, logic [31:0] v);
    int gap;
    in_valid <= 1'b1;
    action   <= a;
    position <= p;
    column   <= c;
    value    <= v;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.apply_item(a, p, c, v);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // sender pause: nothing more goes in until every result is back
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_columns(logic [4:0] v);
    wait_all_results();
    repeat (3) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    sb.set_columns(v);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // well-formed items most of the time; grow favors inserts, otherwise deletes
  task automatic random_item(bit grow);
    int unsigned cnt, cols, r;
    logic [1:0] a;
    logic [4:0] p;
    logic [3:0] c;
    cnt  = sb.count;
    cols = sb.active_cols();
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_item(2'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                4'($urandom_range(0, 15)), $urandom);
      return;
    end
    r = $urandom_range(0, 99);
    if (grow)
      a = (r < 35) ? ACT_STAGE : (r < 70) ? ACT_INSERT : (r < 80) ? ACT_DELETE : ACT_READ;
    else
      a = (r < 15) ? ACT_STAGE : (r < 25) ? ACT_INSERT : (r < 70) ? ACT_DELETE : ACT_READ;
    c = 4'($urandom_range(0, cols - 1));
    case (a)
      ACT_INSERT: begin
        r = $urandom_range(0, 3);
        p = (r == 0) ? 5'd0 : (r == 1) ? cnt[4:0] : 5'($urandom_range(0, cnt));
      end
      ACT_DELETE, ACT_READ: begin
        r = $urandom_range(0, 3);
        if (cnt == 0) p = 5'd0;
        else p = (r == 0) ? 5'd0 : (r == 1) ? 5'(cnt - 1) : 5'($urandom_range(0, cnt - 1));
      end
      default: p = 5'($urandom_range(0, 31));
    endcase
    send_item(a, p, c, pick_value());
  endtask

  // receiver: random stall runs, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.match_result(status, row_count, read_value);
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [4:0] settings [10];
    settings = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd3, 5'd2, 5'd15, 5'd16};
    settings[6] = 5'($urandom_range(3, 14));
    sb = new();
    sb.clear_state();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table, out-of-range positions, extreme values
    send_item(ACT_READ,   5'd0,  4'd0,  32'h0);
    send_item(ACT_DELETE, 5'd0,  4'd0,  32'h0);
    send_item(ACT_READ,   5'd31, 4'd15, 32'hffff_ffff);
    send_item(ACT_STAGE,  5'd31, 4'd0,  32'h8000_0000);
    send_item(ACT_STAGE,  5'd0,  4'd15, 32'h7fff_ffff);
    send_item(ACT_STAGE,  5'd0,  4'd5,  32'hffff_ffff);
    send_item(ACT_INSERT, 5'd1,  4'd0,  32'h0);
    send_item(ACT_INSERT, 5'd0,  4'd0,  32'h0);
    send_item(ACT_INSERT, 5'd31, 4'd0,  32'h0);
    send_item(ACT_READ,   5'd0,  4'd0,  32'h0);
    send_item(ACT_READ,   5'd0,  4'd15, 32'h0);
    send_item(ACT_READ,   5'd0,  4'd5,  32'h0);
    send_item(ACT_STAGE,  5'd0,  4'd0,  32'h5555_5555);
    send_item(ACT_INSERT, 5'd1,  4'd0,  32'h0);   // at the end
    send_item(ACT_STAGE,  5'd0,  4'd0,  32'haaaa_aaaa);
    send_item(ACT_INSERT, 5'd0,  4'd0,  32'h0);   // at the front
    send_item(ACT_READ,   5'd1,  4'd0,  32'h0);
    send_item(ACT_READ,   5'd2,  4'd0,  32'h0);
    send_item(ACT_READ,   5'd3,  4'd0,  32'h0);
    send_item(ACT_DELETE, 5'd3,  4'd0,  32'h0);
    send_item(ACT_DELETE, 5'd1,  4'd0,  32'h0);   // middle row
    send_item(ACT_DELETE, 5'd31, 4'd0,  32'h0);
    send_item(ACT_READ,   5'd1,  4'd0,  32'h0);
    // zero columns acts as one column
    write_columns(5'd0);
    send_item(ACT_STAGE,  5'd0,  4'd1,  32'h1234_5678);
    send_item(ACT_READ,   5'd0,  4'd1,  32'h0);
    send_item(ACT_READ,   5'd0,  4'd0,  32'h0);

    for (int ph = 0; ph < 10; ph++) begin
      write_columns(settings[ph]);
      if (ph == 2) hold_req = 1'b1;
      quiet = (ph == 4);
      for (int k = 0; k < PHASE_ITEMS; k++)
        random_item(k < PHASE_ITEMS / 2);
    end
    quiet = 1'b0;

    wait_all_results();
    repeat (5) @(posedge clk);
    $display("ran %0d items and %0d results over %0d column settings", sb.items_seen,
             sb.results_seen, settings_used);
    $display("outcomes: ok %0d, bad position %0d, full %0d, empty %0d, bad column %0d",
             sb.status_hits[0], sb.status_hits[1], sb.status_hits[2], sb.status_hits[3],
             sb.status_hits[4]);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
design/rti_pkg.sv
design/rti_row_cell.sv
design/row_table_insert_delete.sv
tb/row_table_insert_delete_tb.sv
